>>> rtl/core/ras_pkg.sv
// Package: command codes, register index, sequencer step codes, control word type and the microcode table.
package ras_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register index as seen at paddr[2].
  localparam logic REG_USED_LENGTH = 1'b0;
  localparam logic [8:0] USED_LENGTH_RESET = 9'd1;

  typedef logic [2:0] step_t;
  localparam step_t S_IDLE = 3'd0;
  localparam step_t S_TEST = 3'd1;
  localparam step_t S_RMID = 3'd2;
  localparam step_t S_RHI  = 3'd3;
  localparam step_t S_DEC  = 3'd4;
  localparam step_t S_EMIT = 3'd5;

  typedef logic [1:0] rsel_t;
  localparam rsel_t RS_LOAD = 2'd0;
  localparam rsel_t RS_LO   = 2'd1;
  localparam rsel_t RS_MID  = 2'd2;
  localparam rsel_t RS_HI   = 2'd3;

  typedef logic [2:0] cond_t;
  localparam cond_t C_GO    = 3'd0;  // always jump to target
  localparam cond_t C_START = 3'd1;  // jump on an accepted query, else hold
  localparam cond_t C_EMPTY = 3'd2;  // jump when the range is empty, else advance
  localparam cond_t C_HIT   = 3'd3;  // jump when the middle word matches, else advance
  localparam cond_t C_OUT   = 3'd4;  // jump once the result register is free, else hold

  typedef struct packed {
    logic  in_ready;
    rsel_t rsel;
    logic  ld_mid;
    logic  cap_lo;
    logic  cap_mid;
    logic  update;
    cond_t cond;
    step_t target;
  } uword_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '0;
    unique case (s)
      S_IDLE: begin
        w.in_ready = 1'b1; w.rsel = RS_LOAD; w.cond = C_START; w.target = S_TEST;
      end
      S_TEST: begin
        w.rsel = RS_LO; w.ld_mid = 1'b1; w.cond = C_EMPTY; w.target = S_EMIT;
      end
      S_RMID: begin
        w.rsel = RS_MID; w.cap_lo = 1'b1; w.cond = C_GO; w.target = S_RHI;
      end
      S_RHI: begin
        w.rsel = RS_HI; w.cap_mid = 1'b1; w.cond = C_HIT; w.target = S_EMIT;
      end
      S_DEC: begin
        w.update = 1'b1; w.cond = C_GO; w.target = S_TEST;
      end
      S_EMIT: begin
        w.cond = C_OUT; w.target = S_IDLE;
      end
      default: begin
        w.cond = C_GO; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/ras_in_if.sv
// Interface: input item channel (load or query).
interface ras_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [7:0]         addr;
  logic signed [31:0] value;
  modport source (output valid, cmd, addr, value, input ready);
  modport sink   (input valid, cmd, addr, value, output ready);
endinterface

>>> rtl/core/ras_out_if.sv
// Interface: result item channel (found flag and position).
interface ras_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [7:0] position;
  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

>>> rtl/core/ras_ram.sv
// Generic single-port RAM with registered read.
module ras_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/core/rotated_array_search.sv
// Top level: binary search over a rotated ascending array, microcoded control.
//
// Items arrive on the item channel. A load (cmd 0) writes value at addr into
// the element store in the cycle it is accepted and gives no result; loads
// stream at one item per cycle while no query is at work. A query (cmd 1)
// searches the first used_length elements for value and gives one result
// item: found and the matching position (0 when absent).
// Each probe of a query runs in steps: the single RAM port reads the low,
// middle and high words in turn and a fourth step narrows the bounds. A hit
// ends at the third step of its probe. One query is at work at a time; the
// next item can be taken as soon as the result is in the output register.
// The output register holds a result until the receiver takes it; while it
// is full a finished query waits in its last step and holds off the next
// item. Loads and a new query are still taken while the block is idle.
// The user must write used_length (APB port, byte address 0) only while the
// block is idle; the block does not check it. Reset clears the sequencer,
// the output register and sets used_length to 1; the store starts undefined.
module rotated_array_search import ras_pkg::*; #(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  ras_in_if.sink      item,
  ras_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = AW + 2;
  localparam logic [31:0] DEPTH_W = 32'(DEPTH);
  localparam logic signed [IW-1:0] IDX_ONE = IW'(1);

  logic [8:0]                  used_length;
  step_t                       step, step_next;
  uword_t                      uw;
  logic signed [IW-1:0]        lo, hi, mid, mid_c, hi_init;
  logic signed [WORD_BITS-1:0] key, key_in, a_lo, a_mid, rd_s;
  logic                        hit, hit_now, accept, start, out_free;
  logic [63:0]                 value_x;
  logic [31:0]                 len_sat;
  logic [AW-1:0]               ram_addr;
  logic                        ram_we;
  logic [WORD_BITS-1:0]        ram_rdata;
  logic                        res_valid, res_found;
  logic [7:0]                  res_pos;

  assign uw         = ucode(step);
  assign item.ready = uw.in_ready;
  assign accept     = item.valid & item.ready;
  assign start      = accept & (item.cmd == CMD_QUERY);
  assign out_free   = ~res_valid | result.ready;

  // Sign-extend to 64 bits, cut to the word width.
  assign value_x = 64'(item.value);
  assign key_in  = $signed(value_x[WORD_BITS-1:0]);

  assign len_sat = ({23'b0, used_length} > DEPTH_W) ? DEPTH_W : {23'b0, used_length};
  assign hi_init = $signed(len_sat[IW-1:0] - {{(IW-1){1'b0}}, 1'b1});
  assign mid_c   = lo + ((hi - lo) >>> 1);

  always_comb begin
    unique case (uw.rsel)
      RS_LOAD: ram_addr = AW'(item.addr);
      RS_LO:   ram_addr = lo[AW-1:0];
      RS_MID:  ram_addr = mid[AW-1:0];
      RS_HI:   ram_addr = hi[AW-1:0];
      default: ram_addr = '0;
    endcase
  end

  // Drop loads beyond the store.
  assign ram_we = accept & (item.cmd == CMD_LOAD) & ({24'b0, item.addr} < DEPTH_W);

  ras_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (key_in),
    .rdata (ram_rdata)
  );

  assign rd_s    = $signed(ram_rdata);
  assign hit_now = (uw.cond == C_HIT) & (rd_s == key);

  always_comb begin
    step_next = step;
    unique case (uw.cond)
      C_GO:    step_next = uw.target;
      C_START: if (start) step_next = uw.target;
      C_EMPTY: step_next = (lo > hi) ? uw.target : step_t'(step + 1'b1);
      C_HIT:   step_next = hit_now ? uw.target : step_t'(step + 1'b1);
      C_OUT:   if (out_free) step_next = uw.target;
      default: step_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Search datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      key <= key_in;
      lo  <= '0;
      hi  <= hi_init;
      hit <= 1'b0;
    end
    if (uw.ld_mid) begin
      mid <= mid_c;
    end
    if (uw.cap_lo) begin
      a_lo <= rd_s;
    end
    if (uw.cap_mid) begin
      a_mid <= rd_s;
    end
    if (hit_now) begin
      hit <= 1'b1;
    end
    // The high word arrives on the read port in this step.
    if (uw.update) begin
      if (a_lo <= a_mid) begin
        if (a_lo <= key && key < a_mid) begin
          hi <= mid - IDX_ONE;
        end else begin
          lo <= mid + IDX_ONE;
        end
      end else begin
        if (a_mid < key && key <= rd_s) begin
          lo <= mid + IDX_ONE;
        end else begin
          hi <= mid - IDX_ONE;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (uw.cond == C_OUT && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.cond == C_OUT && out_free) begin
      res_found <= hit;
      res_pos   <= hit ? 8'($unsigned(mid)) : 8'd0;
    end
  end

  assign result.valid    = res_valid;
  assign result.found    = res_found;
  assign result.position = res_pos;

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_length <= USED_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_USED_LENGTH) begin
      used_length <= pwdata[8:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_USED_LENGTH) ? {23'b0, used_length} : 32'd0;

  mid_in_range: assert property (@(posedge clk) disable iff (rst)
    (step == S_RMID) |-> (lo <= mid && mid <= hi))
    else $error("probe index outside the search range");

  range_shrinks: assert property (@(posedge clk) disable iff (rst)
    (step == S_DEC) |=> ((hi - lo) < $past(hi - lo)))
    else $error("search range did not narrow");

  miss_position_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.found) |-> (result.position == 8'd0))
    else $error("miss reported with nonzero position");

endmodule
